>>> hw/rtl/phls_pkg.sv
// Shared types and constants for the proximity head lift sequencer.
// Holds the transaction payload structs, register indexes and reset values.
// No dependencies.
package phls_pkg;

  // Width of the internal millisecond time base; differences wrap at 2^TIME_WIDTH
  localparam int TIME_WIDTH = 32;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 32;

  typedef logic [TIME_WIDTH-1:0] time_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_NEAR_THRESHOLD = 3'd0,
    REG_LOWERED_WAIT   = 3'd1,
    REG_RAISED_WAIT    = 3'd2,
    REG_MOTOR_RUN      = 3'd3,
    REG_LED_PERIOD     = 3'd4,
    REG_SERVO_DOWN     = 3'd5,
    REG_SERVO_UP       = 3'd6
  } cfg_reg_t;

  // Register reset values
  localparam logic [15:0] NEAR_THRESHOLD_RST = 16'd300;
  localparam logic [31:0] LOWERED_WAIT_RST   = 32'd1000;
  localparam logic [31:0] RAISED_WAIT_RST    = 32'd1000;
  localparam logic [31:0] MOTOR_RUN_RST      = 32'd5000;
  localparam logic [31:0] LED_PERIOD_RST     = 32'd10;
  localparam logic [7:0]  SERVO_DOWN_RST     = 8'd10;
  localparam logic [7:0]  SERVO_UP_RST       = 8'd100;

  // Largest servo angle the head accepts
  localparam logic [7:0]  ANGLE_MAX = 8'd180;

  // One poll
  typedef struct packed {
    logic [15:0] distance_mm;
    logic [31:0] now_ms;
  } in_t;

  // One result
  typedef struct packed {
    logic       motor_a;
    logic       motor_b;
    logic [7:0] servo_angle;
    logic       led_level;
    logic [2:0] phase_now;
  } out_t;

endpackage

>>> hw/rtl/proximity_head_lift_sequencer.sv
// Top level of the proximity head lift sequencer: input register, sequencer
// update logic, result register and configuration registers.
// Depends on phls_pkg.

// Each transaction on the input carries one distance sample and a millisecond
// timestamp and produces exactly one result transaction. The block is a
// two-register pipeline: a poll is captured in the input register, then the
// sequencer state and the result register are updated from it once the result
// register is free, so a poll waits in the input register while the output is
// stalled. One poll is accepted every cycle while the output is not stalled.
// All elapsed times are taken modulo 2^32. Configuration writes are to be made
// only while no poll is in flight; they take effect on the next poll.
module proximity_head_lift_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  // poll input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  phls_pkg::in_t                       in_data,
  // result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output phls_pkg::out_t                      out_data,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [phls_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [phls_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);

  typedef enum logic [2:0] {
    PH_LOWERED     = 3'd0,
    PH_DETECT_LOW  = 3'd1,
    PH_RAISING     = 3'd2,
    PH_RAISED      = 3'd3,
    PH_DETECT_HIGH = 3'd4,
    PH_LOWERING    = 3'd5
  } phase_t;

  // Configuration registers
  logic [15:0] near_thr_r;
  logic [31:0] lowered_wait_r, raised_wait_r, motor_run_r, led_period_r;
  logic [7:0]  servo_down_r, servo_up_r;

  // Input stage
  logic          in_valid_r;
  phls_pkg::in_t in_data_r;

  // Sequencer state
  phase_t          phase_r, phase_nxt;
  phls_pkg::time_t lowered_since_r, lowered_since_nxt;
  phls_pkg::time_t raised_since_r, raised_since_nxt;
  phls_pkg::time_t motion_start_r, motion_start_nxt;
  phls_pkg::time_t led_last_r, led_last_nxt;
  logic            led_on_r, led_on_nxt;
  logic            drive_a_r, drive_a_nxt;
  logic            drive_b_r, drive_b_nxt;
  logic [7:0]      servo_pos_r, servo_pos_nxt;

  // Output stage
  logic           out_valid_r;
  phls_pkg::out_t out_data_r;

  logic            advance;
  logic            near;
  phls_pkg::time_t now_t;

  function automatic phls_pkg::time_t elapsed(phls_pkg::time_t now, phls_pkg::time_t then);
    return now - then;
  endfunction

  function automatic logic [7:0] clamp_angle(logic [7:0] a);
    return (a > phls_pkg::ANGLE_MAX) ? phls_pkg::ANGLE_MAX : a;
  endfunction

  // Pipeline control: stage 2 fires when the result register is free
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign now_t = phls_pkg::time_t'(in_data_r.now_ms);
  assign near  = in_data_r.distance_mm < near_thr_r;

  // Sequencer next state
  always_comb begin
    phase_nxt         = phase_r;
    lowered_since_nxt = lowered_since_r;
    raised_since_nxt  = raised_since_r;
    motion_start_nxt  = motion_start_r;
    drive_a_nxt       = drive_a_r;
    drive_b_nxt       = drive_b_r;
    servo_pos_nxt     = servo_pos_r;
    led_on_nxt        = led_on_r;
    led_last_nxt      = led_last_r;

    case (phase_r)
      PH_DETECT_LOW: begin
        if (near) begin
          phase_nxt        = PH_RAISING;
          motion_start_nxt = now_t;
        end else begin
          phase_nxt = PH_LOWERED;
        end
      end
      PH_RAISING: begin
        drive_a_nxt = 1'b0;
        drive_b_nxt = 1'b1;
        if (elapsed(now_t, motion_start_r) >= motor_run_r) begin
          drive_b_nxt      = 1'b0;
          servo_pos_nxt    = clamp_angle(servo_up_r);
          motion_start_nxt = now_t;
          raised_since_nxt = now_t;
          phase_nxt        = PH_RAISED;
        end
      end
      PH_RAISED: begin
        if (elapsed(now_t, raised_since_r) >= raised_wait_r) begin
          phase_nxt        = PH_DETECT_HIGH;
          raised_since_nxt = now_t;
        end
      end
      PH_DETECT_HIGH: begin
        if (near) begin
          phase_nxt = PH_RAISED;
        end else begin
          phase_nxt        = PH_LOWERING;
          motion_start_nxt = now_t;
        end
      end
      PH_LOWERING: begin
        drive_a_nxt = 1'b1;
        drive_b_nxt = 1'b0;
        if (elapsed(now_t, motion_start_r) >= motor_run_r) begin
          drive_a_nxt       = 1'b0;
          servo_pos_nxt     = clamp_angle(servo_down_r);
          motion_start_nxt  = now_t;
          lowered_since_nxt = now_t;
          phase_nxt         = PH_LOWERED;
        end
      end
      default: begin
        // lowered wait, also recovers from unused codes
        phase_nxt     = PH_LOWERED;
        drive_a_nxt   = 1'b0;
        drive_b_nxt   = 1'b0;
        servo_pos_nxt = clamp_angle(servo_down_r);
        if (elapsed(now_t, lowered_since_r) >= lowered_wait_r) begin
          phase_nxt         = PH_DETECT_LOW;
          lowered_since_nxt = now_t;
        end
      end
    endcase

    // status LED blink
    if (elapsed(now_t, led_last_r) >= led_period_r) begin
      led_on_nxt   = !led_on_r;
      led_last_nxt = now_t;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_thr_r     <= phls_pkg::NEAR_THRESHOLD_RST;
      lowered_wait_r <= phls_pkg::LOWERED_WAIT_RST;
      raised_wait_r  <= phls_pkg::RAISED_WAIT_RST;
      motor_run_r    <= phls_pkg::MOTOR_RUN_RST;
      led_period_r   <= phls_pkg::LED_PERIOD_RST;
      servo_down_r   <= phls_pkg::SERVO_DOWN_RST;
      servo_up_r     <= phls_pkg::SERVO_UP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        phls_pkg::REG_NEAR_THRESHOLD: near_thr_r     <= cfg_wdata[15:0];
        phls_pkg::REG_LOWERED_WAIT:   lowered_wait_r <= cfg_wdata[31:0];
        phls_pkg::REG_RAISED_WAIT:    raised_wait_r  <= cfg_wdata[31:0];
        phls_pkg::REG_MOTOR_RUN:      motor_run_r    <= cfg_wdata[31:0];
        phls_pkg::REG_LED_PERIOD:     led_period_r   <= cfg_wdata[31:0];
        phls_pkg::REG_SERVO_DOWN:     servo_down_r   <= cfg_wdata[7:0];
        phls_pkg::REG_SERVO_UP:       servo_up_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // Sequencer state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_LOWERED;
      lowered_since_r <= '0;
      raised_since_r  <= '0;
      motion_start_r  <= '0;
      led_last_r      <= '0;
      led_on_r        <= 1'b0;
      drive_a_r       <= 1'b0;
      drive_b_r       <= 1'b0;
      servo_pos_r     <= phls_pkg::SERVO_DOWN_RST;
      out_valid_r     <= 1'b0;
    end else begin
      if (advance) begin
        phase_r         <= phase_nxt;
        lowered_since_r <= lowered_since_nxt;
        raised_since_r  <= raised_since_nxt;
        motion_start_r  <= motion_start_nxt;
        led_last_r      <= led_last_nxt;
        led_on_r        <= led_on_nxt;
        drive_a_r       <= drive_a_nxt;
        drive_b_r       <= drive_b_nxt;
        servo_pos_r     <= servo_pos_nxt;
        out_valid_r     <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (advance) begin
      out_data_r.motor_a     <= drive_a_nxt;
      out_data_r.motor_b     <= drive_b_nxt;
      out_data_r.servo_angle <= servo_pos_nxt;
      out_data_r.led_level   <= led_on_nxt;
      out_data_r.phase_now   <= phase_nxt;
    end
  end

  // Checks
  a_motor_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(drive_a_r && drive_b_r))
    else $error("both motor lines driven");

  a_motor_only_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.motor_a || out_data_r.motor_b) |->
      (out_data_r.phase_now == PH_RAISING || out_data_r.phase_now == PH_LOWERING))
    else $error("motor driven outside a motion phase");

  a_servo_range: assert property (@(posedge clk) disable iff (!rst_n)
    servo_pos_r <= phls_pkg::ANGLE_MAX)
    else $error("servo angle above limit");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_valid_r && $stable(in_data_r))
    else $error("stalled input register lost its poll");

endmodule

>>> dv/tb.sv
// Testbench for the proximity head lift sequencer: directed and random polls with
// random idling and output holdoff, each result predicted and checked field by field.
// Depends on phls_pkg and proximity_head_lift_sequencer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY        = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 64;
  localparam int MAX_REPORTS    = 10;

  // Index past the last register; writes to it must be dropped
  localparam logic [phls_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [2:0] {
    PH_LOWERED     = 3'd0,
    PH_DETECT_LOW  = 3'd1,
    PH_RAISING     = 3'd2,
    PH_RAISED      = 3'd3,
    PH_DETECT_HIGH = 3'd4,
    PH_LOWERING    = 3'd5
  } lift_phase_t;

  typedef struct {
    logic [15:0] near;
    logic [31:0] low_wait;
    logic [31:0] high_wait;
    logic [31:0] run;
    logic [31:0] led;
    logic [7:0]  down;
    logic [7:0]  up;
  } lift_cfg_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_stall;
  phls_pkg::in_t                        in_data;
  logic                                 out_valid;
  logic                                 out_stall;
  phls_pkg::out_t                       out_data;
  logic                                 cfg_we;
  logic [phls_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [phls_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata;

  proximity_head_lift_sequencer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the configuration registers
  logic [15:0] thr_mm       = phls_pkg::NEAR_THRESHOLD_RST;
  logic [31:0] low_wait_ms  = phls_pkg::LOWERED_WAIT_RST;
  logic [31:0] high_wait_ms = phls_pkg::RAISED_WAIT_RST;
  logic [31:0] run_ms       = phls_pkg::MOTOR_RUN_RST;
  logic [31:0] blink_ms     = phls_pkg::LED_PERIOD_RST;
  logic [7:0]  down_deg     = phls_pkg::SERVO_DOWN_RST;
  logic [7:0]  up_deg       = phls_pkg::SERVO_UP_RST;

  // Predicted sequencer state
  lift_phase_t     lift_phase = PH_LOWERED;
  phls_pkg::time_t lowered_at = '0;
  phls_pkg::time_t raised_at  = '0;
  phls_pkg::time_t motion_at  = '0;
  phls_pkg::time_t led_at     = '0;
  logic            led_q      = 1'b0;
  logic            drive_a_q  = 1'b0;
  logic            drive_b_q  = 1'b0;
  logic [7:0]      servo_q    = phls_pkg::SERVO_DOWN_RST;

  phls_pkg::out_t  lift_results_q[$];
  int unsigned     mismatch_cnt = 0;
  int unsigned     quiet_cycles = 0;
  phls_pkg::time_t clock_ms     = '0;
  int              idle_pct     = 25;
  logic            rx_hold_req  = 1'b0;

  function automatic logic [7:0] sat_angle(input logic [7:0] a);
    return (a > phls_pkg::ANGLE_MAX) ? phls_pkg::ANGLE_MAX : a;
  endfunction

  // One poll through the sequencer; time differences wrap at the time width
  function automatic phls_pkg::out_t advance_lift(input logic [15:0] range_mm,
                                                  input phls_pkg::time_t now);
    logic            is_near;
    phls_pkg::time_t dt;
    phls_pkg::out_t  r;
    is_near = range_mm < thr_mm;
    case (lift_phase)
      PH_DETECT_LOW: begin
        if (is_near) begin
          lift_phase = PH_RAISING;
          motion_at = now;
        end else begin
          lift_phase = PH_LOWERED;
        end
      end
      PH_RAISING: begin
        drive_a_q = 1'b0;
        drive_b_q = 1'b1;
        dt = now - motion_at;
        if (dt >= run_ms) begin
          drive_b_q = 1'b0;
          servo_q = sat_angle(up_deg);
          motion_at = now;
          raised_at = now;
          lift_phase = PH_RAISED;
        end
      end
      PH_RAISED: begin
        dt = now - raised_at;
        if (dt >= high_wait_ms) begin
          lift_phase = PH_DETECT_HIGH;
          raised_at = now;
        end
      end
      PH_DETECT_HIGH: begin
        if (is_near) begin
          lift_phase = PH_RAISED;
        end else begin
          lift_phase = PH_LOWERING;
          motion_at = now;
        end
      end
      PH_LOWERING: begin
        drive_a_q = 1'b1;
        drive_b_q = 1'b0;
        dt = now - motion_at;
        if (dt >= run_ms) begin
          drive_a_q = 1'b0;
          servo_q = sat_angle(down_deg);
          motion_at = now;
          lowered_at = now;
          lift_phase = PH_LOWERED;
        end
      end
      // lowered wait, also where the unused codes land
      default: begin
        lift_phase = PH_LOWERED;
        drive_a_q = 1'b0;
        drive_b_q = 1'b0;
        servo_q = sat_angle(down_deg);
        dt = now - lowered_at;
        if (dt >= low_wait_ms) begin
          lift_phase = PH_DETECT_LOW;
          lowered_at = now;
        end
      end
    endcase
    // status LED runs independently of the phase
    dt = now - led_at;
    if (dt >= blink_ms) begin
      led_q = ~led_q;
      led_at = now;
    end
    r.motor_a     = drive_a_q;
    r.motor_b     = drive_b_q;
    r.servo_angle = servo_q;
    r.led_level   = led_q;
    r.phase_now   = lift_phase;
    return r;
  endfunction

  // Result checker: oldest prediction against each accepted result
  always @(posedge clk) begin
    phls_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (lift_results_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
          $display("ERROR: unexpected result a=%0b b=%0b servo=%0d led=%0b phase=%0d",
                   out_data.motor_a, out_data.motor_b, out_data.servo_angle,
                   out_data.led_level, out_data.phase_now);
        end
      end else begin
        want = lift_results_q.pop_front();
        if (out_data.motor_a !== want.motor_a || out_data.motor_b !== want.motor_b ||
            out_data.servo_angle !== want.servo_angle ||
            out_data.led_level !== want.led_level ||
            out_data.phase_now !== want.phase_now) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("ERROR: expected a=%0b b=%0b servo=%0d led=%0b phase=%0d",
                     want.motor_a, want.motor_b, want.servo_angle, want.led_level,
                     want.phase_now);
            $display("       got      a=%0b b=%0b servo=%0d led=%0b phase=%0d",
                     out_data.motor_a, out_data.motor_b, out_data.servo_angle,
                     out_data.led_level, out_data.phase_now);
          end
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stall bursts, or a long holdoff on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one poll, with an optional gap first, and predict its result on acceptance
  task automatic send_poll(input logic [15:0] range_mm, input phls_pkg::time_t now);
    phls_pkg::in_t p;
    p.distance_mm = range_mm;
    p.now_ms      = now;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall !== 1'b0);
    lift_results_q.push_back(advance_lift(range_mm, now));
  endtask

  // Stop offering and wait until every predicted result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    while (lift_results_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic put_reg(input logic [phls_pkg::CFG_INDEX_WIDTH-1:0] idx,
                         input logic [phls_pkg::CFG_DATA_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      phls_pkg::REG_NEAR_THRESHOLD: thr_mm       = val[15:0];
      phls_pkg::REG_LOWERED_WAIT:   low_wait_ms  = val;
      phls_pkg::REG_RAISED_WAIT:    high_wait_ms = val;
      phls_pkg::REG_MOTOR_RUN:      run_ms       = val;
      phls_pkg::REG_LED_PERIOD:     blink_ms     = val;
      phls_pkg::REG_SERVO_DOWN:     down_deg     = val[7:0];
      phls_pkg::REG_SERVO_UP:       up_deg       = val[7:0];
      default: ;
    endcase
  endtask

  // Write all registers while idle; junk in unused upper bits must be dropped
  task automatic load_settings(input lift_cfg_t s);
    drain_results();
    put_reg(phls_pkg::REG_NEAR_THRESHOLD, {16'($urandom()), s.near});
    put_reg(phls_pkg::REG_LOWERED_WAIT, s.low_wait);
    put_reg(phls_pkg::REG_RAISED_WAIT, s.high_wait);
    put_reg(phls_pkg::REG_MOTOR_RUN, s.run);
    put_reg(phls_pkg::REG_LED_PERIOD, s.led);
    put_reg(phls_pkg::REG_SERVO_DOWN, {24'($urandom()), s.down});
    put_reg(phls_pkg::REG_SERVO_UP, {24'($urandom()), s.up});
    put_reg(REG_UNUSED, $urandom());
    cfg_we <= 1'b0;
  endtask

  // Mostly forward-moving time with near, far and boundary distances;
  // some backward jumps and some fully random timestamps
  task automatic random_polls(input int n, input logic [31:0] max_step);
    int unsigned pick;
    logic [15:0] range_mm;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 86) begin
        clock_ms += $urandom_range(0, max_step);
      end else if (pick < 94) begin
        clock_ms -= $urandom_range(1, max_step);
      end else begin
        clock_ms = $urandom();
      end
      case ($urandom_range(0, 3))
        0: range_mm = (thr_mm == 0) ? 16'd0 : 16'($urandom_range(0, thr_mm - 1));
        1: range_mm = 16'($urandom_range(thr_mm, 16'hffff));
        2: range_mm = thr_mm - 16'($urandom_range(0, 1));
        default: range_mm = 16'($urandom());
      endcase
      send_poll(range_mm, clock_ms);
    end
  endtask

  // Full raise and lower cycle with reset settings, then a backward time jump
  task automatic test_default_sequence();
    send_poll(16'hffff, 32'd0);
    send_poll(16'hffff, 32'd500);
    send_poll(16'd400, 32'd1000);
    send_poll(16'd299, 32'd1001);
    send_poll(16'd0, 32'd3000);
    send_poll(16'd300, 32'd6001);
    send_poll(16'd300, 32'd7001);
    send_poll(16'd0, 32'd7002);
    send_poll(16'd1, 32'd8002);
    send_poll(16'hffff, 32'd8003);
    send_poll(16'hffff, 32'd13003);
    send_poll(16'hffff, 32'd5);
    send_poll(16'd0, 32'hffff_ffff);
  endtask

  // Zero waits finish on first test; angles above the servo limit saturate
  task automatic test_zero_durations();
    lift_cfg_t s;
    s = '{near: 16'hffff, low_wait: '0, high_wait: '0, run: '0, led: '0,
          down: 8'd255, up: 8'd181};
    load_settings(s);
    send_poll(16'd0, 32'h8000_0000);
    send_poll(16'd0, 32'h8000_0000);
    send_poll(16'd0, 32'h8000_0000);
    send_poll(16'hffff, 32'h8000_0000);
    send_poll(16'hffff, 32'h8000_0000);
    send_poll(16'hffff, 32'h8000_0000);
    send_poll(16'd0, 32'h8000_0001);
  endtask

  // Threshold zero (never near), maximal durations, angle limits
  task automatic test_range_extremes();
    lift_cfg_t s;
    s = '{near: 16'd0, low_wait: 32'hffff_ffff, high_wait: 32'hffff_ffff,
          run: 32'hffff_ffff, led: 32'hffff_ffff, down: 8'd0,
          up: phls_pkg::ANGLE_MAX};
    load_settings(s);
    send_poll(16'd0, 32'h0000_0000);
    send_poll(16'hffff, 32'hffff_ffff);
    send_poll(16'd0, 32'h7fff_ffff);
    send_poll(16'd0, 32'hffff_fffe);
  endtask

  // Several register settings, each followed by a random poll sequence
  task automatic test_random_settings();
    lift_cfg_t   s;
    logic [31:0] step;
    for (int round = 0; round < 7; round++) begin
      s.near = 16'($urandom());
      s.down = 8'($urandom());
      s.up   = 8'($urandom());
      case (round)
        0: begin
          s.low_wait = $urandom_range(0, 6);
          s.high_wait = $urandom_range(0, 6);
          s.run = $urandom_range(0, 8);
          s.led = $urandom_range(0, 3);
          step = 4;
        end
        1: begin
          s.near = 16'($urandom_range(0, 2000));
          s.low_wait = $urandom_range(0, 40);
          s.high_wait = $urandom_range(0, 40);
          s.run = $urandom_range(0, 60);
          s.led = $urandom_range(0, 20);
          s.down = 8'($urandom_range(0, 180));
          s.up = 8'($urandom_range(0, 180));
          step = 16;
        end
        2: begin
          s = '{near: phls_pkg::NEAR_THRESHOLD_RST,
                low_wait: phls_pkg::LOWERED_WAIT_RST,
                high_wait: phls_pkg::RAISED_WAIT_RST,
                run: phls_pkg::MOTOR_RUN_RST,
                led: phls_pkg::LED_PERIOD_RST,
                down: phls_pkg::SERVO_DOWN_RST,
                up: phls_pkg::SERVO_UP_RST};
          step = 1500;
        end
        3, 4: begin
          s.near = (round == 3) ? 16'd0 : 16'hffff;
          s.low_wait = $urandom_range(0, 10);
          s.high_wait = $urandom_range(0, 10);
          s.run = $urandom_range(0, 10);
          s.led = $urandom_range(0, 5);
          step = 6;
        end
        5: begin
          s.low_wait = $urandom();
          s.high_wait = $urandom();
          s.run = $urandom();
          s.led = $urandom();
          step = 32'h4000_0000;
        end
        default: begin
          s.low_wait = 32'hffff_ffff;
          s.high_wait = 32'hffff_ffff;
          s.run = 32'hffff_ffff;
          s.led = '0;
          s.down = 8'($urandom_range(181, 255));
          s.up = 8'($urandom_range(181, 255));
          step = 8;
        end
      endcase
      load_settings(s);
      idle_pct = 10 + $urandom_range(0, 40);
      random_polls(95, step);
    end
  endtask

  // Long output holdoff while polls keep coming, so the input backs up
  task automatic test_output_holdoff();
    lift_cfg_t s;
    s = '{near: 16'd1000, low_wait: 32'd2, high_wait: 32'd2, run: 32'd3, led: 32'd1,
          down: 8'd45, up: 8'd135};
    load_settings(s);
    idle_pct = 20;
    rx_hold_req = 1'b1;
    random_polls(40, 3);
    drain_results();
  endtask

  // Closing stretch with no idling on either side
  task automatic test_back_to_back();
    lift_cfg_t s;
    s = '{near: 16'($urandom_range(0, 3000)), low_wait: $urandom_range(0, 20),
          high_wait: $urandom_range(0, 20), run: $urandom_range(0, 30),
          led: $urandom_range(0, 8), down: 8'($urandom_range(0, 180)),
          up: 8'($urandom_range(0, 180))};
    load_settings(s);
    idle_pct = 0;
    random_polls(100, 10);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = phls_pkg::REG_NEAR_THRESHOLD;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_default_sequence();
    test_zero_durations();
    test_range_extremes();
    test_random_settings();
    test_output_holdoff();
    test_back_to_back();

    drain_results();
    if (mismatch_cnt == 0 && lift_results_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
